// ===== rtl/core/rtt_mean_deviation_estimator_top_assert.svh =====
// Assertion macros for the RTT estimator core.
// Included by the top level; uses clk_i and rst_ni of the including module.
`ifndef RTT_MEAN_DEVIATION_ESTIMATOR_TOP_ASSERT_SVH
`define RTT_MEAN_DEVIATION_ESTIMATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RMDE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rmde assertion failed");
`define RMDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmde assertion failed");
`else
`define RMDE_ASSERT(lbl, prop)
`define RMDE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/rmde_pkg.sv =====
// Shared types and constants for the RTT estimator core.
// No dependencies.
package rmde_pkg;
  localparam int unsigned HistDepthDef  = 16;
  localparam int unsigned MaxBackoffDef = 64;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_BACKOFF = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_e;

  localparam logic [2:0] REG_SRTT_GAIN   = 3'd0;
  localparam logic [2:0] REG_DEV_GAIN    = 3'd1;
  localparam logic [2:0] REG_MIN_RTO     = 3'd2;
  localparam logic [2:0] REG_MAX_RTO     = 3'd3;
  localparam logic [2:0] REG_INITIAL_RTT = 3'd4;

  localparam int unsigned MulAW = 35;
  localparam int unsigned MulBW = 16;
  localparam int unsigned MulPW = MulAW + MulBW;

  typedef struct packed {
    logic        retx;
    logic [31:0] tsend;
    logic [31:0] seq;
  } hist_entry_t;
endpackage

// ===== rtl/core/rmde_mem.sv =====
// History memory: one write port, one registered read port.
// Depends on rmde_pkg (entry type).
module rmde_mem #(
  parameter int unsigned DEPTH = rmde_pkg::HistDepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  rmde_pkg::hist_entry_t    wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output rmde_pkg::hist_entry_t    rdata_o
);
  import rmde_pkg::*;

  hist_entry_t mem [DEPTH];
  hist_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/rmde_mul.sv =====
// Shared multiplier with registered product.
// Depends on rmde_pkg (operand widths).
module rmde_mul (
  input  logic                       clk_i,
  input  logic [rmde_pkg::MulAW-1:0] a_i,
  input  logic [rmde_pkg::MulBW-1:0] b_i,
  output logic [rmde_pkg::MulPW-1:0] p_o
);
  import rmde_pkg::*;

  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;
endmodule

// ===== rtl/core/rtt_mean_deviation_estimator_top.sv =====
// Top level of the RTT mean-deviation estimator with retransmit timeout.
// Depends on rmde_pkg, rmde_mem, rmde_mul and the assertion macro header.
//
// channel | direction | handshake              | payload
// --------+-----------+------------------------+---------------------------------
// command | in        | start, busy            | command_i, seq_number_i, now_time_i
// result  | out       | done_o (1-cycle strobe)| rtt_sample_o, sample_valid_o,
//         |           |                        | entry_found_o, table_full_o,
//         |           |                        | timeout_value_o
// config  | in        | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// A word is taken when start is high and busy low; busy stays high until
// the result word strobes on done_o. Send and ack scan the history entry by
// entry through the single memory read port (a read and a compare state per
// entry); an ack then compacts the table, a read and a write state per moved
// entry. Backoff and reset go straight to the timeout states ST_RTO0/ST_RTO1.
// All gain and timeout multiplies share one registered multiplier.
// Reset is asynchronous active low; config is always ready. The receiver
// cannot stall: done_o is high for one cycle only; the result fields hold until the next command.
module rtt_mean_deviation_estimator_top #(
  parameter int unsigned HISTORY_DEPTH = rmde_pkg::HistDepthDef,
  parameter int unsigned MAX_BACKOFF   = rmde_pkg::MaxBackoffDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] now_time_i,
  output logic [31:0] rtt_sample_o,
  output logic        sample_valid_o,
  output logic        entry_found_o,
  output logic        table_full_o,
  output logic [31:0] timeout_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import rmde_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [7:0]  MaxMult = 8'(MAX_BACKOFF);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_SH_RD, ST_SH_WR, ST_EST_SEL,
    ST_EST0, ST_EST1, ST_EST2, ST_EST3, ST_RTO0, ST_RTO1
  } state_e;

  state_e      state_q;
  logic [1:0]  cmd_q;
  logic [31:0] seq_q, now_q;
  logic [CW-1:0] idx_q, count_q;
  logic [31:0] srtt_q, dev_q, aerr_q, dmag_q;
  logic        eneg_q, dneg_q, have_q;
  logic [6:0]  mult_q;
  logic [15:0] srtt_gain_q, dev_gain_q;
  logic [31:0] min_rto_q, max_rto_q, init_rtt_q;
  logic        done_q, valid_q, found_q, full_q;
  logic [31:0] sample_q, rto_q;

  // memory and multiplier hookup
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  hist_entry_t mem_wdata, mem_rdata;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;

  logic [CW-1:0] idx_nx;
  assign idx_nx = idx_q + CW'(1);

  rmde_mem #(.DEPTH(HISTORY_DEPTH)) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  rmde_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // rounded gain product: (p + 0.5) >> 16
  logic [48:0] rnd_sum;
  logic [32:0] rnd;
  assign rnd_sum = {1'b0, mul_p[47:0]} + 49'd32768;
  assign rnd     = rnd_sum[48:16];

  function automatic logic [31:0] sat_adj(input logic [31:0] b, input logic [32:0] r,
                                          input logic neg);
    logic [33:0] s;
    s = neg ? ({2'b0, b} - {1'b0, r}) : ({2'b0, b} + {1'b0, r});
    if (neg) begin
      sat_adj = s[33] ? 32'd0 : s[31:0];
    end else begin
      sat_adj = (s[33:32] != 2'b0) ? 32'hFFFF_FFFF : s[31:0];
    end
  endfunction

  logic [32:0] err, derr;
  logic [34:0] base, base_m;
  assign err    = {1'b0, sample_q} - {1'b0, srtt_q};
  assign derr   = {1'b0, aerr_q} - {1'b0, dev_q};
  assign base   = {3'b0, srtt_q} + {1'b0, dev_q, 2'b0};
  assign base_m = (base < {3'b0, min_rto_q}) ? {3'b0, min_rto_q} : base;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = idx_q[AW-1:0];
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_SCAN_RD: begin
        if (idx_q >= count_q && cmd_q == CMD_SEND && count_q < CW'(HISTORY_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[AW-1:0];
          mem_wdata = '{retx: 1'b0, tsend: now_q, seq: seq_q};
        end
      end
      ST_SCAN_CMP: begin
        if (mem_rdata.seq == seq_q && cmd_q == CMD_SEND) begin
          mem_we         = 1'b1;
          mem_wdata.retx = 1'b1;
        end
      end
      ST_SH_RD: mem_raddr = idx_nx[AW-1:0];
      ST_SH_WR: mem_we = 1'b1;
      ST_EST0: begin
        mul_a = MulAW'(eneg_q ? aerr_q : aerr_q);
        mul_b = srtt_gain_q;
      end
      ST_EST2: begin
        mul_a = MulAW'(dmag_q);
        mul_b = dev_gain_q;
      end
      ST_RTO0: begin
        mul_a = base_m;
        mul_b = MulBW'(mult_q);
      end
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srtt_gain_q <= 16'd8192;
      dev_gain_q  <= 16'd16384;
      min_rto_q   <= 32'd200000;
      max_rto_q   <= 32'hFFFF_FFFF;
      init_rtt_q  <= 32'd1000000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SRTT_GAIN:   srtt_gain_q <= cfg_data_i[15:0];
        REG_DEV_GAIN:    dev_gain_q  <= cfg_data_i[15:0];
        REG_MIN_RTO:     min_rto_q   <= cfg_data_i;
        REG_MAX_RTO:     max_rto_q   <= cfg_data_i;
        REG_INITIAL_RTT: init_rtt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      count_q <= '0;
      idx_q   <= '0;
      srtt_q  <= 32'd1000000;
      dev_q   <= '0;
      have_q  <= 1'b0;
      mult_q  <= 7'd1;
      valid_q <= 1'b0;
      found_q <= 1'b0;
      full_q  <= 1'b0;
      cmd_q   <= CMD_SEND;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q    <= command_i;
            seq_q    <= seq_number_i;
            now_q    <= now_time_i;
            idx_q    <= '0;
            valid_q  <= 1'b0;
            found_q  <= 1'b0;
            full_q   <= 1'b0;
            sample_q <= '0;
            case (command_i)
              CMD_SEND, CMD_ACK: state_q <= ST_SCAN_RD;
              CMD_BACKOFF: begin
                mult_q  <= ({mult_q, 1'b0} > MaxMult) ? MaxMult[6:0] : {mult_q[5:0], 1'b0};
                state_q <= ST_RTO0;
              end
              default: begin
                count_q <= '0;
                srtt_q  <= init_rtt_q;
                dev_q   <= '0;
                have_q  <= 1'b0;
                mult_q  <= 7'd1;
                state_q <= ST_RTO0;
              end
            endcase
          end
        end
        ST_SCAN_RD: begin
          if (idx_q < count_q) begin
            state_q <= ST_SCAN_CMP;
          end else begin
            // no match: a send appends or reports a full table
            if (cmd_q == CMD_SEND) begin
              if (count_q < CW'(HISTORY_DEPTH)) count_q <= count_q + CW'(1);
              else full_q <= 1'b1;
            end
            state_q <= ST_RTO0;
          end
        end
        ST_SCAN_CMP: begin
          if (mem_rdata.seq == seq_q) begin
            found_q <= 1'b1;
            if (cmd_q == CMD_SEND) begin
              state_q <= ST_RTO0;
            end else begin
              if (!mem_rdata.retx) begin
                valid_q  <= 1'b1;
                sample_q <= now_q - mem_rdata.tsend;
                mult_q   <= 7'd1;
              end
              state_q <= ST_SH_RD;
            end
          end else begin
            idx_q   <= idx_nx;
            state_q <= ST_SCAN_RD;
          end
        end
        ST_SH_RD: begin
          if (idx_nx < count_q) begin
            state_q <= ST_SH_WR;
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= valid_q ? ST_EST_SEL : ST_RTO0;
          end
        end
        ST_SH_WR: begin
          idx_q   <= idx_nx;
          state_q <= ST_SH_RD;
        end
        ST_EST_SEL: begin
          if (have_q) begin
            eneg_q  <= err[32];
            aerr_q  <= err[32] ? 32'(-err) : err[31:0];
            state_q <= ST_EST0;
          end else begin
            srtt_q  <= sample_q;
            dev_q   <= {1'b0, sample_q[31:1]};
            have_q  <= 1'b1;
            state_q <= ST_RTO0;
          end
        end
        ST_EST0: state_q <= ST_EST1;
        ST_EST1: begin
          srtt_q  <= sat_adj(srtt_q, rnd, eneg_q);
          dneg_q  <= derr[32];
          dmag_q  <= derr[32] ? 32'(-derr) : derr[31:0];
          state_q <= ST_EST2;
        end
        ST_EST2: state_q <= ST_EST3;
        ST_EST3: begin
          dev_q   <= sat_adj(dev_q, rnd, dneg_q);
          state_q <= ST_RTO0;
        end
        ST_RTO0: state_q <= ST_RTO1;
        ST_RTO1: begin
          rto_q   <= (mul_p > MulPW'(max_rto_q)) ? max_rto_q : mul_p[31:0];
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign rtt_sample_o    = sample_q;
  assign sample_valid_o  = valid_q;
  assign entry_found_o   = found_q;
  assign table_full_o    = full_q;
  assign timeout_value_o = rto_q;

`include "rtt_mean_deviation_estimator_top_assert.svh"
  `RMDE_ASSERT(a_done_idle, !done_o || !busy)
  `RMDE_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `RMDE_ASSERT(a_count_range, count_q <= CW'(HISTORY_DEPTH))
  `RMDE_ASSERT(a_valid_found, !(done_o && sample_valid_o && !entry_found_o))
endmodule
